FILE: rtl/core/oax_pkg.sv
// Shared types and constants for the octant angle block.
`default_nettype none
package oax_pkg;

   localparam int unsigned COMP_W     = 8;
   localparam int unsigned ANGLE_W    = 7;
   localparam int unsigned DIVIDEND_W = 14;
   localparam int unsigned QUO_W      = 6;
   localparam int unsigned CNT_W      = 4;

   localparam logic [ANGLE_W-1:0] ANGLE_ZERO = 7'd0;
   localparam logic [ANGLE_W-1:0] ANGLE_HALF = 7'd45;
   localparam logic [ANGLE_W-1:0] ANGLE_FULL = 7'd90;
   localparam logic [CNT_W-1:0]   LAST_BIT   = 4'(DIVIDEND_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [COMP_W-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/oax_div.sv
// Restoring shift-and-subtract divider, one quotient bit per cycle.
`default_nettype none
module oax_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire oax_pkg::div_req_type div_req,
   output oax_pkg::div_rsp_type      div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [oax_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [oax_pkg::DIVIDEND_W-1:0]     num_ff, num_in;
   logic [oax_pkg::COMP_W-1:0]         rem_ff, rem_in;
   logic [oax_pkg::COMP_W-1:0]         den_ff, den_in;
   logic [oax_pkg::QUO_W-1:0]          quo_ff, quo_in;
   logic [oax_pkg::COMP_W:0]           trial;
   logic [oax_pkg::COMP_W:0]           diff;
   logic                               ge;

   always_comb begin
      trial = {rem_ff, num_ff[oax_pkg::DIVIDEND_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = oax_pkg::LAST_BIT;
         num_in  = div_req.dividend;
         den_in  = div_req.divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[oax_pkg::DIVIDEND_W-2:0], 1'b0};
         rem_in = ge ? diff[oax_pkg::COMP_W-1:0] : trial[oax_pkg::COMP_W-1:0];
         quo_in = {quo_ff[oax_pkg::QUO_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

FILE: rtl/core/octant_angle_from_xy.sv
// Top level: first-quadrant angle in degrees from two unsigned components.
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  req     | req_valid, req_ready, req_adjacent, req_opposite | in
//  rsp     | rsp_valid, rsp_ready, rsp_angle          | out
//
// Equal, zero-adjacent or zero-opposite words skip the divider: angle, then output stage.
// Others go through 14 divider steps, one angle stage and one output stage.
// req_ready is high only in ST_IDLE: no new word until the last has left ST_WRITE.
// Synchronous active-high reset clears the sequencer, divider control and rsp_valid.
// A stalled rsp holds its word; a finished result waits in ST_WRITE until the slot frees.
`default_nettype none
module octant_angle_from_xy (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [oax_pkg::COMP_W-1:0]    req_adjacent,
   input  wire logic [oax_pkg::COMP_W-1:0]    req_opposite,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [oax_pkg::ANGLE_W-1:0]   rsp_angle
);

   oax_pkg::state_type                state_ff, state_in;
   oax_pkg::div_req_type              div_req;
   oax_pkg::div_rsp_type              div_rsp;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [oax_pkg::ANGLE_W-1:0]       rsp_angle_ff, rsp_angle_in;
   logic [oax_pkg::ANGLE_W-1:0]       angle_ff, angle_in;
   logic                              low_ff, low_in;
   logic                              accept;
   logic                              special;
   logic                              slot_free;
   logic                              load_rsp;
   logic [oax_pkg::ANGLE_W-1:0]       special_angle;
   logic [oax_pkg::COMP_W-1:0]        small_comp;
   logic [oax_pkg::COMP_W-1:0]        big_comp;
   logic                              adj_gt;
   logic [oax_pkg::ANGLE_W-1:0]       quo_ext;

   always_comb begin
      adj_gt        = (req_adjacent > req_opposite);
      small_comp    = adj_gt ? req_opposite : req_adjacent;
      big_comp      = adj_gt ? req_adjacent : req_opposite;
      special       = 1'b1;
      special_angle = oax_pkg::ANGLE_HALF;
      if (req_adjacent == req_opposite) begin
         special_angle = oax_pkg::ANGLE_HALF;
      end else if (req_adjacent == '0) begin
         special_angle = oax_pkg::ANGLE_FULL;
      end else if (req_opposite == '0) begin
         special_angle = oax_pkg::ANGLE_ZERO;
      end else begin
         special = 1'b0;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign quo_ext   = {{(oax_pkg::ANGLE_W-oax_pkg::QUO_W){1'b0}}, div_rsp.quotient};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oax_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = special ? oax_pkg::ST_WRITE : oax_pkg::ST_DIV;
            end
         end
         oax_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               state_in = oax_pkg::ST_WRITE;
            end
         end
         oax_pkg::ST_WRITE: begin
            if (slot_free) begin
               state_in = oax_pkg::ST_IDLE;
            end
         end
         default: state_in = oax_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         oax_pkg::ST_IDLE:  req_ready = 1'b1;
         oax_pkg::ST_DIV:   req_ready = 1'b0;
         oax_pkg::ST_WRITE: load_rsp  = slot_free;
         default:           req_ready = 1'b0;
      endcase
   end

   always_comb begin
      div_req.start    = accept && !special;
      div_req.dividend = oax_pkg::DIVIDEND_W'(small_comp)
                       * oax_pkg::DIVIDEND_W'(oax_pkg::ANGLE_HALF);
      div_req.divisor  = big_comp;
   end

   always_comb begin
      angle_in = angle_ff;
      low_in   = low_ff;
      if (accept) begin
         angle_in = special_angle;
         low_in   = adj_gt;
      end else if (div_rsp.done) begin
         angle_in = low_ff ? quo_ext : oax_pkg::ANGLE_FULL - quo_ext;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_angle_in = rsp_angle_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_angle_in = angle_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oax_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      angle_ff     <= angle_in;
      low_ff       <= low_in;
      rsp_angle_ff <= rsp_angle_in;
   end

   oax_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = rsp_angle_ff;

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle <= oax_pkg::ANGLE_FULL))
      else $error("angle out of range");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == oax_pkg::ST_DIV))
      else $error("divider finished outside division");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != oax_pkg::ST_IDLE))
      else $error("accepted word did not leave idle");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_rsp.done)
      else $error("divider done straight after start");

endmodule
`default_nettype wire
